// ----- rtl/ecsf_pkg.sv -----
`default_nettype none

package ecsf_pkg;

   localparam int NUM_ENCODERS = 2;
   localparam int ENC_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_INVERT = 2'd2;

   localparam int ALPHA_W   = 17;
   localparam int DIR_INV_W = 2;

   localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = 17'd16384;
   localparam logic [ALPHA_W-1:0]   ALPHA_ONE     = 17'd65536;
   localparam logic [DIR_INV_W-1:0] DIR_INV_RESET = 2'd2;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Shared multiplier: signed operand times unsigned operand, registered product.
   localparam int MUL_A_W = 43;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = 60;
   localparam int ACC_W   = 50;

   typedef struct packed {
      logic opcode;
      logic encoder_id;
      logic b_level;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pulse_count;
      logic signed [31:0] speed_rpm;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_RAW,
      ST_DIFF,
      ST_MUL_ALPHA,
      ST_STEP,
      ST_UPDATE,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/encoder_count_and_speed_filter_core.sv -----
`default_nettype none

// Channel    | Direction | Handshake            | Payload
// req_       | in        | req_valid/req_ready  | ecsf_pkg::req_type
// rsp_       | out       | rsp_valid/rsp_ready  | ecsf_pkg::rsp_type
// csr_       | in        | csr_we, no wait      | csr_index, csr_wdata
//
// An edge transaction updates the count in the accept cycle; its result is
// registered at that same edge. A tick transaction walks the encoders on one
// shared 43x17 multiplier, stepping MUL_LO, MUL_HI, SUM, RAW, DIFF, MUL_ALPHA,
// STEP and UPDATE per encoder, then registers its result from RESP. Requests
// are taken only in idle with the result register free or being drained. Reset
// is synchronous and resets counts, filter state, CSRs, the FSM and rsp_valid.

module encoder_count_and_speed_filter_core (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_ready,
   input  ecsf_pkg::req_type                         req_data,
   output logic                                      rsp_valid,
   input  wire                                       rsp_ready,
   output ecsf_pkg::rsp_type                         rsp_data,
   input  wire                                       csr_we,
   input  wire  [ecsf_pkg::CSR_IDX_W-1:0]            csr_index,
   input  wire  [ecsf_pkg::CSR_DATA_W-1:0]           csr_wdata
);

   ecsf_pkg::state_type state_ff, state_in;

   logic [31:0]                        scale_ff, scale_in;
   logic [ecsf_pkg::ALPHA_W-1:0]       alpha_ff, alpha_in;
   logic [ecsf_pkg::DIR_INV_W-1:0]     dir_inv_ff, dir_inv_in;

   logic [15:0]        counter_ff [ecsf_pkg::NUM_ENCODERS];
   logic [15:0]        counter_in [ecsf_pkg::NUM_ENCODERS];
   logic [15:0]        prev_ff    [ecsf_pkg::NUM_ENCODERS];
   logic [15:0]        prev_in    [ecsf_pkg::NUM_ENCODERS];
   logic signed [31:0] filt_ff    [ecsf_pkg::NUM_ENCODERS];
   logic signed [31:0] filt_in    [ecsf_pkg::NUM_ENCODERS];

   logic [ecsf_pkg::ENC_W-1:0]         enc_idx_ff, enc_idx_in;
   logic                               id_ff, id_in;
   logic signed [ecsf_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [ecsf_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ecsf_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic [ecsf_pkg::ENC_W-1:0]          addr;
   logic [15:0]                         cnt_rd;
   logic [15:0]                         prev_rd;
   logic signed [31:0]                  filt_rd;
   logic [15:0]                         delta;
   logic signed [ecsf_pkg::MUL_A_W-1:0] delta_ext;
   logic signed [ecsf_pkg::ACC_W-1:0]   filt_ext;
   logic [ecsf_pkg::ALPHA_W-1:0]        alpha_eff;
   logic signed [ecsf_pkg::MUL_A_W-1:0] mul_a;
   logic [ecsf_pkg::MUL_B_W-1:0]        mul_b;
   logic signed [ecsf_pkg::MUL_A_W+ecsf_pkg::MUL_B_W:0] mul_full;
   logic signed [ecsf_pkg::PROD_W-1:0]  rnd_prod;
   logic signed [ecsf_pkg::ACC_W-1:0]   new_filt;
   logic [15:0]                         cnt_next;
   logic                                inv_bit;
   logic                                req_fire;

   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // One read port on the encoder state: the request in idle, the reported
   // encoder when answering a tick, the loop index otherwise.
   always_comb begin
      case (state_ff)
         ecsf_pkg::ST_IDLE: begin
            addr = ecsf_pkg::ENC_W'(req_data.encoder_id);
         end
         ecsf_pkg::ST_RESP: begin
            addr = ecsf_pkg::ENC_W'(id_ff);
         end
         default: begin
            addr = enc_idx_ff;
         end
      endcase
   end

   assign cnt_rd    = counter_ff[addr];
   assign prev_rd   = prev_ff[addr];
   assign filt_rd   = filt_ff[addr];
   assign delta     = cnt_rd - prev_rd;
   assign delta_ext = $signed({{(ecsf_pkg::MUL_A_W-16){delta[15]}}, delta});
   assign filt_ext  = $signed({{(ecsf_pkg::ACC_W-32){filt_rd[31]}}, filt_rd});
   assign alpha_eff = (alpha_ff > ecsf_pkg::ALPHA_ONE) ? ecsf_pkg::ALPHA_ONE : alpha_ff;
   assign inv_bit   = (int'(addr) < ecsf_pkg::DIR_INV_W) ? dir_inv_ff[addr] : 1'b0;
   assign mul_full  = mul_a * $signed({1'b0, mul_b});

   // Ties round away from zero: add half, minus one for negative values.
   assign rnd_prod  = prod_ff + (prod_ff[ecsf_pkg::PROD_W-1] ?
                                 ecsf_pkg::PROD_W'(32767) : ecsf_pkg::PROD_W'(32768));
   assign new_filt  = acc_ff + filt_ext;

   always_comb begin
      state_in     = state_ff;
      scale_in     = scale_ff;
      alpha_in     = alpha_ff;
      dir_inv_in   = dir_inv_ff;
      counter_in   = counter_ff;
      prev_in      = prev_ff;
      filt_in      = filt_ff;
      enc_idx_in   = enc_idx_ff;
      id_in        = id_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      mul_a        = $signed(acc_ff[ecsf_pkg::MUL_A_W-1:0]);
      mul_b        = alpha_eff;
      cnt_next     = (req_data.b_level ^ inv_bit) ? cnt_rd + 16'd1 : cnt_rd - 16'd1;

      if (csr_we) begin
         case (csr_index)
            ecsf_pkg::CSR_SPEED_SCALE: begin
               scale_in = csr_wdata;
            end
            ecsf_pkg::CSR_FILTER_ALPHA: begin
               alpha_in = csr_wdata[ecsf_pkg::ALPHA_W-1:0];
            end
            ecsf_pkg::CSR_DIRECTION_INVERT: begin
               dir_inv_in = csr_wdata[ecsf_pkg::DIR_INV_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ecsf_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_fire) begin
               id_in = req_data.encoder_id;
               if (req_data.opcode == ecsf_pkg::OP_TICK) begin
                  enc_idx_in = '0;
                  state_in   = ecsf_pkg::ST_MUL_LO;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (int'(req_data.encoder_id) < ecsf_pkg::NUM_ENCODERS) begin
                     counter_in[addr]        = cnt_next;
                     rsp_data_in.pulse_count = $signed(cnt_next);
                     rsp_data_in.speed_rpm   = filt_rd;
                  end else begin
                     rsp_data_in = '0;
                  end
               end
            end
         end
         ecsf_pkg::ST_MUL_LO: begin
            mul_a    = delta_ext;
            mul_b    = {1'b0, scale_ff[15:0]};
            prod_in  = mul_full[ecsf_pkg::PROD_W-1:0];
            state_in = ecsf_pkg::ST_MUL_HI;
         end
         ecsf_pkg::ST_MUL_HI: begin
            acc_in   = prod_ff[ecsf_pkg::ACC_W-1:0];
            mul_a    = delta_ext;
            mul_b    = {1'b0, scale_ff[31:16]};
            prod_in  = mul_full[ecsf_pkg::PROD_W-1:0];
            state_in = ecsf_pkg::ST_SUM;
         end
         ecsf_pkg::ST_SUM: begin
            acc_in   = $signed({prod_ff[ecsf_pkg::ACC_W-17:0], 16'd0}) + acc_ff;
            state_in = ecsf_pkg::ST_RAW;
         end
         ecsf_pkg::ST_RAW: begin
            acc_in   = (acc_ff + (acc_ff[ecsf_pkg::ACC_W-1] ?
                        ecsf_pkg::ACC_W'(127) : ecsf_pkg::ACC_W'(128))) >>> 8;
            state_in = ecsf_pkg::ST_DIFF;
         end
         ecsf_pkg::ST_DIFF: begin
            acc_in   = acc_ff - filt_ext;
            state_in = ecsf_pkg::ST_MUL_ALPHA;
         end
         ecsf_pkg::ST_MUL_ALPHA: begin
            prod_in  = mul_full[ecsf_pkg::PROD_W-1:0];
            state_in = ecsf_pkg::ST_STEP;
         end
         ecsf_pkg::ST_STEP: begin
            acc_in   = $signed({{(ecsf_pkg::ACC_W-ecsf_pkg::PROD_W+16)
                                  {rnd_prod[ecsf_pkg::PROD_W-1]}},
                                rnd_prod[ecsf_pkg::PROD_W-1:16]});
            state_in = ecsf_pkg::ST_UPDATE;
         end
         ecsf_pkg::ST_UPDATE: begin
            if (new_filt > ecsf_pkg::ACC_W'(64'sd2147483647)) begin
               filt_in[addr] = 32'sh7fffffff;
            end else if (new_filt < -ecsf_pkg::ACC_W'(64'sd2147483648)) begin
               filt_in[addr] = 32'sh80000000;
            end else begin
               filt_in[addr] = new_filt[31:0];
            end
            prev_in[addr] = cnt_rd;
            if (enc_idx_ff == ecsf_pkg::ENC_W'(ecsf_pkg::NUM_ENCODERS - 1)) begin
               state_in = ecsf_pkg::ST_RESP;
            end else begin
               enc_idx_in = ecsf_pkg::ENC_W'(enc_idx_ff + 1'b1);
               state_in   = ecsf_pkg::ST_MUL_LO;
            end
         end
         ecsf_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (int'(id_ff) < ecsf_pkg::NUM_ENCODERS) begin
                  rsp_data_in.pulse_count = $signed(cnt_rd);
                  rsp_data_in.speed_rpm   = filt_rd;
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ecsf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ecsf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecsf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= '0;
         alpha_ff     <= ecsf_pkg::ALPHA_RESET;
         dir_inv_ff   <= ecsf_pkg::DIR_INV_RESET;
         enc_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ecsf_pkg::NUM_ENCODERS; i++) begin
            counter_ff[i] <= '0;
            prev_ff[i]    <= '0;
            filt_ff[i]    <= '0;
         end
      end else begin
         scale_ff     <= scale_in;
         alpha_ff     <= alpha_in;
         dir_inv_ff   <= dir_inv_in;
         enc_idx_ff   <= enc_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         counter_ff   <= counter_in;
         prev_ff      <= prev_in;
         filt_ff      <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A tick transaction always starts the encoder walk at the first encoder.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.opcode == ecsf_pkg::OP_TICK)
         |=> (state_ff == ecsf_pkg::ST_MUL_LO && enc_idx_ff == '0))
      else $error("tick did not start the encoder walk");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.opcode == ecsf_pkg::OP_EDGE) |=> rsp_valid_ff)
      else $error("edge transaction produced no result");

   // Once the walk is done every snapshot matches its live count; the check covers encoder 0.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ecsf_pkg::ST_RESP) |-> (prev_ff[0] == counter_ff[0]))
      else $error("previous count not refreshed by tick");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ecsf_pkg::ST_RESP && rsp_valid_ff && !rsp_ready)
         |=> (state_ff == ecsf_pkg::ST_RESP))
      else $error("tick result would overwrite a pending result");

endmodule

`default_nettype wire
